>>> rtl/brr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the nibble decode function for the brr voice decoder
// no dependencies; used by brr_sample_filter and brr_adpcm_voice_decoder
package brr_pkg;

   localparam int VOICES      = 8;
   localparam int VOICE_W     = 3;
   localparam int PHASE_W     = 4;
   localparam int BLOCK_BYTES = 8;
   localparam int RANGE_MAX   = 12;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_KEY_ON = 1'b1;

   localparam logic [1:0] END_MID  = 2'd0;
   localparam logic [1:0] END_NEXT = 2'd1;
   localparam logic [1:0] END_LOOP = 2'd2;
   localparam logic [1:0] END_STOP = 2'd3;

   localparam logic [1:0] FILT_NONE = 2'd0;
   localparam logic [1:0] FILT_ONE  = 2'd1;
   localparam logic [1:0] FILT_TWO  = 2'd2;
   localparam logic [1:0] FILT_THR  = 2'd3;

   // block header context plus filter history for one voice
   typedef struct packed {
      logic [3:0]         shift_range;
      logic [1:0]         filter_select;
      logic signed [15:0] prev_sample;
      logic signed [15:0] older_sample;
   } filt_ctx_type;

   function automatic logic signed [15:0] decode_nibble(
      input logic [3:0]         nib,
      input logic [3:0]         rng,
      input logic [1:0]         filt,
      input logic signed [15:0] p,
      input logic signed [15:0] o
   );
      logic signed [21:0] t;
      logic signed [21:0] pw;
      logic signed [21:0] ow;
      logic signed [21:0] acc;
      t  = 22'($signed(nib));
      pw = 22'(p);
      ow = 22'(o);
      if (rng <= 4'(RANGE_MAX)) begin
         t = t <<< rng;
      end else begin
         t = nib[3] ? -22'sd2048 : 22'sd0;
      end
      case (filt)
         FILT_ONE: begin
            acc = t + pw + ((-pw) >>> 4);
         end
         FILT_TWO: begin
            acc = t + (pw <<< 1) + ((-(pw * 22'sd3)) >>> 5) - ow + (ow >>> 4);
         end
         FILT_THR: begin
            acc = t + (pw <<< 1) + ((-(pw * 22'sd13)) >>> 6) - ow
                  + ((ow * 22'sd3) >>> 4);
         end
         default: begin
            acc = t;
         end
      endcase
      // wraps to 16 bits, no clamp
      return $signed(acc[15:0]);
   endfunction

endpackage

>>> rtl/brr_sample_filter.sv
`timescale 1ns / 1ps
// decodes both nibbles of one brr data byte through the voice's prediction filter
// depends on brr_pkg (filt_ctx_type, decode_nibble)
module brr_sample_filter (
   input  brr_pkg::filt_ctx_type ctx,
   input  logic [7:0]            data_byte,
   output logic signed [15:0]    first_sample,
   output logic signed [15:0]    second_sample
);

   // high nibble first; the low nibble sees it as the newest history sample
   assign first_sample = brr_pkg::decode_nibble(data_byte[7:4], ctx.shift_range,
                                                ctx.filter_select, ctx.prev_sample,
                                                ctx.older_sample);

   assign second_sample = brr_pkg::decode_nibble(data_byte[3:0], ctx.shift_range,
                                                 ctx.filter_select, first_sample,
                                                 ctx.prev_sample);

endmodule

>>> rtl/brr_adpcm_voice_decoder.sv
`timescale 1ns / 1ps
// top level of the brr adpcm voice decoder: input register, per-voice state, result register
// depends on brr_pkg and brr_sample_filter
//
// usage
//   req channel: one beat per stream byte or key-on. tuser carries the operation
//   (data byte or key on), tdata the voice and the byte. each voice keeps its own
//   block position, header and two samples of filter history.
//   rsp channel: one beat per data byte of an active voice, carrying two decoded
//   samples and an end code; headers, key-ons and bytes for silent voices give none.
//   path: a beat is registered in the input register on entry and its result is
//   then loaded into the output register, which drives rsp_tvalid.
//   throughput: one beat per cycle unless a data beat waits on a stalled rsp, set
//   by the state read-modify-write of the per-voice registers; back-to-back beats on
//   the same voice are fine. stall: while rsp_tready is low the result holds; a
//   beat that gives a result then waits in the input register and req_tready drops.
//   reset: all voices silent and expecting a header, history and headers cleared,
//   both channels empty.
module brr_adpcm_voice_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [brr_pkg::REQ_DATA_W-1:0]  req_tdata,   // [2:0] voice, [10:3] data_byte,
                                                        // [15:11] zero
   input  logic [0:0]                      req_tuser,   // [0] operation
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [brr_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [2:0] voice_out, [18:3] first_sample,
                                                        // [34:19] second_sample, [39:35] zero
   output logic [1:0]                      rsp_tuser    // [1:0] end_code
);

   localparam int VN = brr_pkg::VOICES;
   localparam int PW = brr_pkg::PHASE_W;

   // input register
   logic                      in_valid_ff;
   logic                      in_op_ff;
   logic [brr_pkg::VOICE_W-1:0] in_voice_ff;
   logic [7:0]                in_byte_ff;

   // per-voice state
   logic signed [15:0] prev_ff   [VN];
   logic signed [15:0] older_ff  [VN];
   logic [3:0]         range_ff  [VN];
   logic [1:0]         filt_ff   [VN];
   logic [1:0]         flags_ff  [VN];
   logic [PW-1:0]      phase_ff  [VN];
   logic               active_ff [VN];

   // result register
   logic                      out_valid_ff;
   logic [brr_pkg::VOICE_W-1:0] out_voice_ff;
   logic signed [15:0]        out_first_ff;
   logic signed [15:0]        out_second_ff;
   logic [1:0]                out_code_ff;

   // next values for the addressed voice
   logic signed [15:0] prev_in;
   logic signed [15:0] older_in;
   logic [3:0]         range_in;
   logic [1:0]         filt_in;
   logic [1:0]         flags_in;
   logic [PW-1:0]      phase_in;
   logic               active_in;
   logic [1:0]         code_in;

   brr_pkg::filt_ctx_type ctx;
   logic signed [15:0]    first_sample;
   logic signed [15:0]    second_sample;

   logic voice_ok;
   logic is_header;
   logic emits;
   logic out_free;
   logic advance;

   assign voice_ok  = int'(in_voice_ff) < VN;
   assign is_header = (phase_ff[in_voice_ff] == '0) ||
                      (phase_ff[in_voice_ff] > PW'(brr_pkg::BLOCK_BYTES));
   assign emits     = in_valid_ff && voice_ok && (in_op_ff == brr_pkg::OP_DATA) &&
                      active_ff[in_voice_ff] && !is_header;
   assign out_free  = !out_valid_ff || rsp_tready;
   assign advance   = in_valid_ff && (!emits || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign ctx.shift_range   = range_ff[in_voice_ff];
   assign ctx.filter_select = filt_ff[in_voice_ff];
   assign ctx.prev_sample   = prev_ff[in_voice_ff];
   assign ctx.older_sample  = older_ff[in_voice_ff];

   brr_sample_filter u_filter (
      .ctx          (ctx),
      .data_byte    (in_byte_ff),
      .first_sample (first_sample),
      .second_sample(second_sample)
   );

   always_comb begin
      prev_in   = prev_ff[in_voice_ff];
      older_in  = older_ff[in_voice_ff];
      range_in  = range_ff[in_voice_ff];
      filt_in   = filt_ff[in_voice_ff];
      flags_in  = flags_ff[in_voice_ff];
      phase_in  = phase_ff[in_voice_ff];
      active_in = active_ff[in_voice_ff];
      code_in   = brr_pkg::END_MID;
      if (in_op_ff == brr_pkg::OP_KEY_ON) begin
         active_in = 1'b1;
         phase_in  = '0;
      end else if (active_ff[in_voice_ff]) begin
         if (is_header) begin
            range_in = in_byte_ff[7:4];
            filt_in  = in_byte_ff[3:2];
            flags_in = in_byte_ff[1:0];
            phase_in = PW'(1);
         end else begin
            prev_in  = second_sample;
            older_in = first_sample;
            if (phase_ff[in_voice_ff] == PW'(brr_pkg::BLOCK_BYTES)) begin
               phase_in = '0;
               // flag bit 0 is end, bit 1 is loop
               if (!flags_ff[in_voice_ff][0]) begin
                  code_in = brr_pkg::END_NEXT;
               end else if (flags_ff[in_voice_ff][1]) begin
                  code_in = brr_pkg::END_LOOP;
               end else begin
                  code_in   = brr_pkg::END_STOP;
                  active_in = 1'b0;
               end
            end else begin
               phase_in = phase_ff[in_voice_ff] + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= req_tuser[0];
         in_voice_ff <= req_tdata[2:0];
         in_byte_ff  <= req_tdata[10:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VN; i++) begin
            prev_ff[i]   <= '0;
            older_ff[i]  <= '0;
            range_ff[i]  <= '0;
            filt_ff[i]   <= '0;
            flags_ff[i]  <= '0;
            phase_ff[i]  <= '0;
            active_ff[i] <= 1'b0;
         end
      end else if (advance && voice_ok) begin
         prev_ff[in_voice_ff]   <= prev_in;
         older_ff[in_voice_ff]  <= older_in;
         range_ff[in_voice_ff]  <= range_in;
         filt_ff[in_voice_ff]   <= filt_in;
         flags_ff[in_voice_ff]  <= flags_in;
         phase_ff[in_voice_ff]  <= phase_in;
         active_ff[in_voice_ff] <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emits) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emits) begin
         out_voice_ff  <= in_voice_ff;
         out_first_ff  <= first_sample;
         out_second_ff <= second_sample;
         out_code_ff   <= code_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_second_ff, out_first_ff, out_voice_ff};
   assign rsp_tuser  = out_code_ff;

endmodule
